/* src/urr_pkg.sv */
// Package: shared types and constants for the ultrasonic round-robin ranger.
`timescale 1ns / 1ps
package urr_pkg;

	typedef logic [1:0] event_kind_t;
	typedef logic [1:0] report_kind_t;

	localparam event_kind_t EV_POLL = 2'd0;
	localparam event_kind_t EV_RISE = 2'd1;
	localparam event_kind_t EV_FALL = 2'd2;

	localparam report_kind_t REP_MEASURED = 2'd0;
	localparam report_kind_t REP_TIMEOUT  = 2'd1;
	localparam report_kind_t REP_TRIGGER  = 2'd2;

	localparam int SENSOR_SLOTS_DEF = 4;
	localparam int CNT_W = 3;
	localparam int TIME_W = 32;
	localparam int DIST_W = 8;
	localparam int IDX_OUT_W = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = 8'd199;
	// (elapsed / 29) / 2 == elapsed / 58; saturation starts at 200 * 58
	localparam int US_PER_CM_RT = 58;
	localparam int ELAP_W = 14;
	localparam logic [TIME_W-1:0] SAT_ELAPSED = TIME_W'((int'(DIST_MAX) + 1) * US_PER_CM_RT);
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W = 15;
	localparam logic [RECIP_W-1:0] RECIP_58 =
		RECIP_W'(((1 << RECIP_SHIFT) + US_PER_CM_RT - 1) / US_PER_CM_RT);

	typedef struct packed {
		report_kind_t             kind;
		logic [IDX_OUT_W-1:0]     index;
		logic [DIST_W-1:0]        dist_cm;
		logic                     last;
	} result_t;

endpackage

/* src/ultrasonic_round_robin_ranger_core.sv */
// Top level: echo timer and round-robin poll sequencer for ultrasonic rangers.
// Latency: an accepted beat is registered in stage 1, then its first result in
// the output register. Throughput: one beat per cycle while each beat gives at
// most one result and m_tready is high; a poll with a timeout report gives two
// results, and a later result waits until the second is taken. Distance is a
// reciprocal multiply on stage 1. Reset clears count, sensor, pending, start time and valid flags.
`timescale 1ns / 1ps
module ultrasonic_round_robin_ranger_core
	import urr_pkg::*;
#(
	parameter int SENSOR_SLOTS = SENSOR_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,     // sensor_count
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,       // [31:0] time_us
	input  logic [1:0]        s_tuser,       // [1:0] event_kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,       // [1:0] sensor_index, [9:2] distance_cm, zero pad
	output logic [1:0]        m_tuser,       // [1:0] report_kind
	output logic              m_tlast        // last_result
);

	localparam int IDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
	localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  active_q;
	logic              pending_q;
	logic [TIME_W-1:0] start_q;

	logic              valid_s1;
	event_kind_t       kind_s1;
	logic [TIME_W-1:0] time_s1;
	logic [ELAP_W-1:0] elap_s1;
	logic              sat_s1;

	logic    outv0_q, outv1_q;
	result_t out0_q, out1_q;

	// stage 0: elapsed time against the start time, forwarded from stage 1
	logic [TIME_W-1:0] start_fwd, elapsed;
	logic              adv_s1;

	assign start_fwd = (valid_s1 && adv_s1 && kind_s1 == EV_RISE) ? time_s1 : start_q;
	assign elapsed   = s_tdata - start_fwd;
	assign s_tready  = !valid_s1 || adv_s1;

	// stage 1: state update and result forming
	logic [CMP_W-1:0]            count_eff, next_cmp;
	logic [IDX_W-1:0]            next_idx;
	logic [ELAP_W+RECIP_W-1:0]   prod;
	logic [DIST_W-1:0]           meas_cm;
	logic [IDX_W+IDX_OUT_W-1:0]  act_ext, nxt_ext;
	logic [1:0]                  n_res;
	result_t                     r0, r1;
	logic                        pop, out_free;

	always_comb begin
		count_eff = (CMP_W'(count_q) > CMP_W'(SENSOR_SLOTS)) ? CMP_W'(SENSOR_SLOTS)
			: CMP_W'(count_q);
		next_cmp = CMP_W'(active_q) + CMP_W'(1);
		next_idx = (next_cmp >= count_eff) ? '0 : next_cmp[IDX_W-1:0];
		prod = elap_s1 * RECIP_58;
		meas_cm = sat_s1 ? DIST_MAX : DIST_W'(prod >> RECIP_SHIFT);
		act_ext = {{IDX_OUT_W{1'b0}}, active_q};
		nxt_ext = {{IDX_OUT_W{1'b0}}, next_idx};
		n_res = 2'd0;
		r0 = '0;
		r1 = '0;
		case (kind_s1)
			EV_POLL: begin
				if (count_eff != '0) begin
					if (pending_q) begin
						n_res = 2'd2;
						r0 = '{kind: REP_TIMEOUT, index: act_ext[IDX_OUT_W-1:0],
							dist_cm: DIST_MAX, last: 1'b0};
						r1 = '{kind: REP_TRIGGER, index: nxt_ext[IDX_OUT_W-1:0],
							dist_cm: '0, last: 1'b1};
					end else begin
						n_res = 2'd1;
						r0 = '{kind: REP_TRIGGER, index: nxt_ext[IDX_OUT_W-1:0],
							dist_cm: '0, last: 1'b1};
					end
				end
			end
			EV_FALL: begin
				n_res = 2'd1;
				r0 = '{kind: REP_MEASURED, index: act_ext[IDX_OUT_W-1:0],
					dist_cm: meas_cm, last: 1'b1};
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

	assign pop      = outv0_q && m_tready;
	assign out_free = !outv0_q || (pop && !outv1_q);
	assign adv_s1   = valid_s1 && (n_res == 2'd0 || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			active_q  <= '0;
			pending_q <= 1'b0;
			start_q   <= '0;
			valid_s1  <= 1'b0;
			outv0_q   <= 1'b0;
			outv1_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				case (kind_s1)
					EV_POLL: begin
						if (count_eff != '0) begin
							active_q  <= next_idx;
							pending_q <= 1'b1;
						end
					end
					EV_RISE: begin
						pending_q <= 1'b1;
						start_q   <= time_s1;
					end
					EV_FALL: begin
						pending_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (adv_s1 && n_res != 2'd0) begin
				outv0_q <= 1'b1;
				outv1_q <= (n_res == 2'd2);
			end else if (pop) begin
				outv0_q <= outv1_q;
				outv1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			time_s1 <= s_tdata;
			elap_s1 <= elapsed[ELAP_W-1:0];
			sat_s1  <= (elapsed >= SAT_ELAPSED);
		end
		if (adv_s1 && n_res != 2'd0) begin
			out0_q <= r0;
			out1_q <= r1;
		end else if (pop) begin
			out0_q <= out1_q;
		end
	end

	assign m_tvalid = outv0_q;
	assign m_tuser  = out0_q.kind;
	assign m_tlast  = out0_q.last;
	assign m_tdata  = {6'd0, out0_q.dist_cm, out0_q.index};

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		outv1_q |-> outv0_q)
		else $error("second result held without first");

	a_poll_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && kind_s1 == EV_POLL && count_eff != '0) |=> pending_q)
		else $error("poll did not mark pulse pending");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(active_q) < SENSOR_SLOTS))
		else $error("active sensor out of range");

	a_timeout_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == REP_TIMEOUT) |-> (!m_tlast && outv1_q))
		else $error("timeout report without trailing trigger");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out0_q.dist_cm <= DIST_MAX))
		else $error("distance above saturation");

endmodule
